### rtl/xor_linear_basis_max_query_core_macros.svh
// assertion macros for the xor linear basis core
`ifndef XOR_LINEAR_BASIS_MAX_QUERY_CORE_MACROS_SVH
`define XOR_LINEAR_BASIS_MAX_QUERY_CORE_MACROS_SVH

// same-cycle implication
`define XLB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xlb check failed");

// next-cycle implication
`define XLB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xlb check failed");

`endif

### rtl/xlb_pkg.sv
// types and constants for the xor linear basis core
package xlb_pkg;

  localparam int WORD_BITS_DEF = 60;
  localparam int VALUE_W       = 60;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_QUERY  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    action_t              action;
    logic [VALUE_W-1:0]   value;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   result_value;
    logic                 inserted;
  } out_t;

endpackage

### rtl/xor_linear_basis_max_query_core.sv
// xor linear basis core: insert, clear and maximum-xor query over a slot memory
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------------
//   input   | in_valid  | in_stall  | in_data  (action, value)
//   output  | out_valid | out_stall | out_data (result_value, inserted)
//
// insert and query walk one basis slot per cycle
// from the top bit down through the slot memory read port; an insert ends at
// the slot it fills. clear and undefined actions go straight to the done state.
// reset empties the basis at once through per-slot valid bits, no clearing pass.
// a finished result waits in the output register while the next transaction
// is accepted; the core holds in its done state only while that register is full and stalled.
`include "xor_linear_basis_max_query_core_macros.svh"

module xor_linear_basis_max_query_core #(
  parameter int WORD_BITS = xlb_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  xlb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output xlb_pkg::out_t out_data
);

  localparam int IW = $clog2(WORD_BITS);
  localparam logic [IW-1:0] TOP = IW'(WORD_BITS - 1);

  xlb_pkg::state_t  state, state_next;
  xlb_pkg::action_t op;
  logic [IW-1:0]        idx;
  logic [WORD_BITS-1:0] cur, cur_next;
  logic                 ins;
  logic [WORD_BITS-1:0] valid;

  logic [WORD_BITS-1:0] mem [WORD_BITS];
  logic [WORD_BITS-1:0] rd_data;
  logic [IW-1:0]        rd_addr;
  logic                 we;
  logic                 walk_end;

  logic                 in_take;
  logic [63:0]          in_wide;
  logic [63:0]          cur_wide;
  logic                 out_load;

  assign in_take  = in_valid && !in_stall;
  assign in_wide  = 64'(in_data.value);
  assign cur_wide = 64'(cur);

  // slot memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= cur;
    end
    rd_data <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      xlb_pkg::ST_IDLE: begin
        if (in_take) begin
          if (in_data.action == xlb_pkg::ACT_INSERT ||
              in_data.action == xlb_pkg::ACT_QUERY) begin
            state_next = xlb_pkg::ST_WALK;
          end else begin
            state_next = xlb_pkg::ST_DONE;
          end
        end
      end
      xlb_pkg::ST_WALK: begin
        if (walk_end) begin
          state_next = xlb_pkg::ST_DONE;
        end
      end
      xlb_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = xlb_pkg::ST_IDLE;
        end
      end
      default: state_next = xlb_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_stall = 1'b1;
    rd_addr  = idx - 1'b1;
    we       = 1'b0;
    walk_end = 1'b0;
    cur_next = cur;
    out_load = 1'b0;
    unique case (state)
      xlb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        rd_addr  = TOP;
      end
      xlb_pkg::ST_WALK: begin
        walk_end = (idx == '0);
        if (op == xlb_pkg::ACT_INSERT) begin
          if (cur[idx]) begin
            if (!valid[idx]) begin
              we       = 1'b1;
              walk_end = 1'b1;
            end else begin
              cur_next = cur ^ rd_data;
            end
          end
        end else if (!cur[idx] && valid[idx]) begin
          cur_next = cur ^ rd_data;
        end
      end
      xlb_pkg::ST_DONE: begin
        out_load = !out_valid || !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= xlb_pkg::ST_IDLE;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_take && in_data.action == xlb_pkg::ACT_CLEAR) begin
        valid <= '0;
      end else if (we) begin
        valid[idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op  <= in_data.action;
      idx <= TOP;
      cur <= in_wide[WORD_BITS-1:0];
      ins <= 1'b0;
    end else if (state == xlb_pkg::ST_WALK) begin
      cur <= cur_next;
      idx <= idx - 1'b1;
      if (we) begin
        ins <= 1'b1;
      end
    end
    if (out_load) begin
      out_data.result_value <= (op == xlb_pkg::ACT_QUERY) ?
                               cur_wide[xlb_pkg::VALUE_W-1:0] : '0;
      out_data.inserted     <= ins && (op == xlb_pkg::ACT_INSERT);
    end
  end

  `XLB_ASSERT_NEXT(a_accept_busy, clk, rst, in_take, state != xlb_pkg::ST_IDLE)
  `XLB_ASSERT_SAME(a_store_empty, clk, rst, we, !valid[idx] && cur[idx])
  `XLB_ASSERT_NEXT(a_store_ends, clk, rst, we, state == xlb_pkg::ST_DONE)
  `XLB_ASSERT_NEXT(a_clear_empties, clk, rst, in_take && in_data.action == xlb_pkg::ACT_CLEAR, valid == '0)
  `XLB_ASSERT_SAME(a_query_no_write, clk, rst, state == xlb_pkg::ST_WALK && op == xlb_pkg::ACT_QUERY, !we)

endmodule
